### sv/tsa_pkg.sv
// tsa_pkg: shared types, codes and constants of the task slot allocator
`default_nettype none

package tsa_pkg;

  // defaults for the top level parameters
  localparam int SLOTS_DEF       = 64;
  localparam int STACK_WORDS_DEF = 1024;
  localparam int ID_BITS_DEF     = 7;

  // fixed field widths
  localparam int GEN_BITS = 9;
  localparam int PRI_BITS = 8;
  localparam int PAR_BITS = 16;
  localparam int ENT_W    = GEN_BITS + PRI_BITS + PAR_BITS;

  // free-slot search groups
  localparam int GRP_W = 8;

  // saved stack pointer sits this many words below the entry word
  localparam logic [15:0] SP_BACK = 16'd15;

  // operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_RETIRE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_NOT_ZOMBIE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
    logic [31:0] entry_addr;
    logic [15:0] parent_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [15:0] saved_sp_offset;
    logic [15:0] entry_word_offset;
    logic [31:0] entry_word;
    logic [7:0]  task_priority;
    logic [15:0] task_parent;
    logic        is_ready;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic find;
    logic read;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

### sv/task_slot_allocator_top.sv
// task_slot_allocator_top: top level of the task slot allocator
`default_nettype none

// task slot table with lowest-free-slot allocation and generation-tagged ids.
// each request word (alloc, free, lookup, retire) gives exactly one response
// word. one request is in flight at a time: it is taken in the idle state,
// then passes the find state, picking a slot from the registered free-slot
// summary (eight-slot groups, refreshed every cycle from the used bitmap), the
// read state, for the registered read of the descriptor ram (generation,
// priority, parent), and the execute state, for the read-modify-write and
// loading the response register, and only then is the next request taken.
// a waiting response only holds the final step; the response
// register parts the two sides. ids pack generation above slot number plus
// one, truncated to 16 bits. there is no clearing pass after reset: a valid
// flop per slot makes a never-written descriptor read as zero, and the used
// and ready flags sit in flops cleared by reset.
module task_slot_allocator_top #(
  parameter int SLOTS       = tsa_pkg::SLOTS_DEF,
  parameter int STACK_WORDS = tsa_pkg::STACK_WORDS_DEF,
  parameter int ID_BITS     = tsa_pkg::ID_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // request channel
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tsa_pkg::req_t req,
  // response channel
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tsa_pkg::rsp_t      rsp
);

  import tsa_pkg::*;

  // command bundle from the sequencer
  cmd_t cmd;

  // sequencer: idle, find, read, execute
  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // slot flags, descriptor ram and response register
  tsa_dp #(
    .SLOTS       (SLOTS),
    .STACK_WORDS (STACK_WORDS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

### sv/tsa_ram.sv
// tsa_ram: generic single write port ram with registered read
`default_nettype none

module tsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/tsa_ctrl.sv
// tsa_ctrl: sequencing state machine of the task slot allocator
`default_nettype none

module tsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tsa_pkg::cmd_t      cmd
);

  import tsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_READ,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.capture = req_valid && req_ready;
    cmd.find    = (state == S_FIND);
    cmd.read    = (state == S_READ);
    // result register must be free or emptying
    cmd.exec    = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      // a new result in the same cycle keeps valid up
      if (rsp_valid && rsp_ready && !cmd.exec) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state     <= S_FIND;
            req_ready <= 1'b0;
          end
        end
        S_FIND: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.exec) begin
            rsp_valid <= 1'b1;
            req_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/tsa_dp.sv
// tsa_dp: slot table, free-slot search and result datapath
`default_nettype none

module tsa_dp #(
  parameter int SLOTS       = tsa_pkg::SLOTS_DEF,
  parameter int STACK_WORDS = tsa_pkg::STACK_WORDS_DEF,
  parameter int ID_BITS     = tsa_pkg::ID_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tsa_pkg::cmd_t cmd,
  input  wire tsa_pkg::req_t req,
  output tsa_pkg::rsp_t      rsp
);

  import tsa_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NGRP   = (SLOTS + GRP_W - 1) / GRP_W;
  localparam int PAD_W  = NGRP * GRP_W;
  localparam int LOW_W  = $clog2(GRP_W);
  localparam int IDW_W  = GEN_BITS + ID_BITS;
  localparam logic [ID_BITS:0] SLOTS_ID = (ID_BITS + 1)'(SLOTS);

  function automatic logic [LOW_W-1:0] low_zero(input logic [GRP_W-1:0] v);
    int i;
    low_zero = '0;
    for (i = GRP_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        low_zero = LOW_W'(i);
      end
    end
  endfunction

  // per-slot flags in flops
  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] ready;
  logic [SLOTS-1:0] valid;

  req_t              req_q;
  logic [SLOT_W-1:0] slot;
  logic              fail;

  // registered free-slot summary
  logic [PAD_W-1:0] used_pad;
  logic [NGRP-1:0]  grp_free;
  logic [LOW_W-1:0] grp_low [NGRP];

  logic [SLOT_W-1:0]  pick_slot;
  logic               pick_any;
  logic [ID_BITS-1:0] field;
  logic               bad;

  logic [ENT_W-1:0]    rd_data;
  logic [ENT_W-1:0]    wr_data;
  logic                wr;
  logic                ram_we;

  logic                hit;
  logic [GEN_BITS-1:0] cur_gen, new_gen;
  logic [PRI_BITS-1:0] cur_pri, new_pri;
  logic [PAR_BITS-1:0] cur_par, new_par;
  logic                cur_rdy, new_rdy, new_used;
  logic [1:0]          st;
  logic [31:0]         top_w;
  logic [15:0]         eow;
  logic [IDW_W-1:0]    idw;
  rsp_t                rsp_next;

  always_comb begin
    used_pad              = '1;
    used_pad[SLOTS-1:0]   = used;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free[g] <= ~&used_pad[g*GRP_W +: GRP_W];
      grp_low[g]  <= low_zero(used_pad[g*GRP_W +: GRP_W]);
    end
  end

  // lowest group with a free slot
  always_comb begin
    pick_slot = '0;
    pick_any  = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        pick_any  = 1'b1;
        pick_slot = SLOT_W'(g * GRP_W + int'(grp_low[g]));
      end
    end
  end

  assign field = req_q.task_id[ID_BITS-1:0];
  assign bad   = (field == '0) || ({1'b0, field} > SLOTS_ID);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.find) begin
      if (req_q.op == OP_ALLOC) begin
        slot <= pick_slot;
        fail <= !pick_any;
      end else if (bad) begin
        slot <= '0;
        fail <= 1'b1;
      end else begin
        slot <= SLOT_W'(int'(field) - 1);
        fail <= 1'b0;
      end
    end
  end

  tsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wr_data),
    .re    (cmd.read),
    .raddr (slot),
    .rdata (rd_data)
  );

  always_comb begin
    hit      = valid[slot];
    cur_gen  = hit ? rd_data[ENT_W-1 -: GEN_BITS] : '0;
    cur_pri  = hit ? rd_data[PAR_BITS +: PRI_BITS] : '0;
    cur_par  = hit ? rd_data[PAR_BITS-1:0] : '0;
    cur_rdy  = ready[slot];
    new_gen  = cur_gen;
    new_pri  = cur_pri;
    new_par  = cur_par;
    new_rdy  = cur_rdy;
    new_used = used[slot];
    wr       = 1'b0;
    st       = ST_OK;
    case (req_q.op)
      OP_ALLOC: begin
        new_used = 1'b1;
        new_rdy  = 1'b1;
        new_pri  = req_q.priority_req;
        new_par  = req_q.parent_id;
        wr       = 1'b1;
      end
      OP_FREE: begin
        if (cur_rdy) begin
          st = ST_NOT_ZOMBIE;
        end else begin
          new_used = 1'b0;
          new_gen  = cur_gen + 1'b1;
          new_par  = '0;
          wr       = 1'b1;
        end
      end
      OP_RETIRE: begin
        new_rdy = 1'b0;
      end
      OP_LOOKUP: begin
      end
      default: begin
      end
    endcase
    wr_data = {new_gen, new_pri, new_par};
    ram_we  = cmd.exec && !fail && wr;

    top_w = 32'(STACK_WORDS * (int'(slot) + 1) - 1);
    eow   = top_w[15:0];
    idw   = {new_gen, ID_BITS'(int'(slot) + 1)};

    rsp_next = '0;
    if (fail) begin
      rsp_next.status = (req_q.op == OP_ALLOC) ? ST_FULL : ST_NOT_ZOMBIE;
    end else begin
      rsp_next.status        = st;
      rsp_next.result_id     = 16'(idw);
      rsp_next.task_priority = new_pri;
      rsp_next.task_parent   = new_par;
      rsp_next.is_ready      = new_rdy;
      if (req_q.op == OP_ALLOC) begin
        rsp_next.saved_sp_offset   = eow - SP_BACK;
        rsp_next.entry_word_offset = eow;
        rsp_next.entry_word        = req_q.entry_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      ready <= '0;
      valid <= '0;
    end else if (cmd.exec && !fail) begin
      used[slot]  <= new_used;
      ready[slot] <= new_rdy;
      if (wr) begin
        valid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### sv/tsa_check.sv
// tsa_check: port-level assertions for the task slot allocator, with bind
`default_nettype none

module tsa_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire tsa_pkg::rsp_t rsp
);

  import tsa_pkg::*;

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // table full gives an empty word
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |->
      rsp.result_id == 16'd0 && rsp.task_parent == 16'd0 && !rsp.is_ready)
    else $error("table full response carries slot data");

  // stack offsets only on a good alloc, and a fixed distance apart
  a_offsets: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.entry_word_offset != 16'd0 || rsp.saved_sp_offset != 16'd0) |->
      rsp.saved_sp_offset == rsp.entry_word_offset - SP_BACK && rsp.status == ST_OK)
    else $error("stack offsets inconsistent");

endmodule

bind task_slot_allocator_top tsa_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
